// File: rtl/spiq_pkg.sv
// shared types and constants for the sorted insertion priority queue
// no dependencies; imported by every module of the block
`default_nettype none
package spiq_pkg;

  localparam int QUEUE_DEPTH   = 64;
  localparam int PRIORITY_BITS = 8;
  localparam int TIME_BITS     = 32;
  localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_BITS      = 7;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] priority_val;
    logic [TIME_BITS-1:0]     arrival;
    logic [TIME_BITS-1:0]     service;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

  typedef struct packed {
    logic                     operation;
    logic [PRIORITY_BITS-1:0] in_priority;
    logic [TIME_BITS-1:0]     in_arrival;
    logic [TIME_BITS-1:0]     in_service;
  } in_item_t;

  typedef struct packed {
    logic                     out_valid;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [TIME_BITS-1:0]     out_arrival;
    logic [TIME_BITS-1:0]     out_service;
    status_t                  status;
    logic [OCC_BITS-1:0]      occupancy;
    logic                     is_empty;
    logic [OCC_BITS-1:0]      peak_occupancy;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/sorted_insertion_priority_queue_top.sv
// Sorted insertion priority queue, top level: a row of spiq_cell slots with
// occupancy tracking and a registered result; depends on spiq_pkg, spiq_cell
//
// Usage: each transfer on the input channel (in_valid/in_ready, in_data) is
// an insert (operation 0) or a removal of the head (operation 1). Every input
// transfer yields exactly one result transfer on the output channel
// (out_valid/out_ready, out_data) carrying the removed entry, a status code,
// occupancy, empty flag and peak occupancy.
// The result is registered at the edge that accepts the item. Throughput is
// one item per cycle while the receiver keeps up; all slots compare against the
// new entry and shift in parallel in that cycle, so the cell row sets the pace.
// in_ready is high while the result register is empty or being drained, so a
// stalled receiver holds off the next item after one result is waiting.
// Reset clears occupancy, peak occupancy and the result valid flag; slot
// contents are not cleared, and only occupied slots are ever read.
`default_nettype none
module sorted_insertion_priority_queue_top
  import spiq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [COUNT_BITS-1:0] peak;
  logic [COUNT_BITS-1:0] peak_next;
  logic                  res_valid;
  out_item_t             res;
  out_item_t             res_next;

  logic       accept;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;
  entry_t     new_entry;

  entry_t                 slot     [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] beats;
  logic [QUEUE_DEPTH-1:0] occupied;

  assign in_ready  = !res_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign full      = (count == COUNT_BITS'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign ctrl.ins  = accept && (in_data.operation == OP_INSERT) && !full;
  assign ctrl.rem  = accept && (in_data.operation == OP_REMOVE) && !empty;

  assign new_entry.priority_val = in_data.in_priority;
  assign new_entry.arrival      = in_data.in_arrival;
  assign new_entry.service      = in_data.in_service;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occupied[i] = (count > COUNT_BITS'(i));
    spiq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied[i]),
      .new_entry   (new_entry),
      .left_entry  ((i == 0) ? new_entry : slot[(i == 0) ? 0 : i - 1]),
      .left_beats  ((i == 0) ? 1'b0 : beats[(i == 0) ? 0 : i - 1]),
      .right_entry (slot[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .entry       (slot[i]),
      .beats       (beats[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.rem) begin
      count_next = count - 1'b1;
    end
    peak_next = (count_next > peak) ? count_next : peak;
  end

  always_comb begin
    res_next                = '0;
    res_next.status         = STATUS_OK;
    if (in_data.operation == OP_INSERT) begin
      if (full) begin
        res_next.status = STATUS_FULL;
      end
    end else if (empty) begin
      res_next.status = STATUS_EMPTY;
    end else begin
      res_next.out_valid    = 1'b1;
      res_next.out_priority = slot[0].priority_val;
      res_next.out_arrival  = slot[0].arrival;
      res_next.out_service  = slot[0].service;
    end
    res_next.occupancy      = OCC_BITS'(count_next);
    res_next.is_empty       = (count_next == '0);
    res_next.peak_occupancy = OCC_BITS'(peak_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      peak      <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      peak  <= peak_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign out_valid = res_valid;
  assign out_data  = res;

endmodule
`default_nettype wire

// File: rtl/spiq_cell.sv
// one slot of the sorted queue: holds an entry, compares it with the new one
// and shifts toward its neighbors; depends on spiq_pkg
`default_nettype none
module spiq_cell
  import spiq_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       occupied,
  input  wire entry_t     new_entry,
  input  wire entry_t     left_entry,
  input  wire logic       left_beats,
  input  wire entry_t     right_entry,
  output entry_t          entry,
  output logic            beats
);

  entry_t entry_next;

  // new entry goes before this slot, empty slots count as beaten
  always_comb begin
    beats = !occupied
         || (new_entry.priority_val > entry.priority_val)
         || (new_entry.priority_val == entry.priority_val
             && new_entry.arrival < entry.arrival);
  end

  always_comb begin
    entry_next = entry;
    if (ctrl.ins && beats) begin
      entry_next = left_beats ? left_entry : new_entry;
    end else if (ctrl.rem) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

// File: rtl/spiq_checker.sv
// port-level checks for the sorted insertion priority queue, bound to the top
// level; depends on spiq_pkg and sorted_insertion_priority_queue_top
`default_nettype none
module spiq_checker
  import spiq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire out_item_t out_data
);

  // a free result register always admits a transfer
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_empty == (out_data.occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.peak_occupancy >= out_data.occupancy))
    else $error("peak below occupancy");

  // rejected insert only when full, removal from empty only when empty
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == STATUS_FULL)
      |-> (out_data.occupancy == OCC_BITS'(QUEUE_DEPTH) && !out_data.out_valid))
    else $error("full status with room left");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == STATUS_EMPTY)
      |-> (out_data.is_empty && !out_data.out_valid))
    else $error("empty status on non-empty queue");

endmodule

bind sorted_insertion_priority_queue_top spiq_checker u_spiq_checker (.*);
`default_nettype wire
